FILE: sv/smc_pkg.sv
package smc_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned LitBit = 15;
  localparam logic [WordW-1:0] TrueWord = 16'hffff;
  localparam logic [WordW-1:0] LitMask = 16'h7fff;
  // compare-and-subtract steps that reduce a 16-bit pointer modulo a memory of at least 256 bytes
  localparam int unsigned ModSteps = 8;

  typedef enum logic [7:0] {
    OP_NOP  = 8'd0,
    OP_CALL = 8'd1,
    OP_RET  = 8'd2,
    OP_IF   = 8'd3,
    OP_NEG  = 8'd4,
    OP_ADD  = 8'd5,
    OP_MUL  = 8'd6,
    OP_DIV  = 8'd7,
    OP_NOT  = 8'd8,
    OP_AND  = 8'd9,
    OP_OR   = 8'd10,
    OP_XOR  = 8'd11,
    OP_TOR  = 8'd12,
    OP_FROMR = 8'd13,
    OP_DUP  = 8'd14,
    OP_DROP = 8'd15,
    OP_SWAP = 8'd16,
    OP_OVER = 8'd17,
    OP_STB  = 8'd18,
    OP_ADDB = 8'd19,
    OP_FETB = 8'd20,
    OP_ADDF = 8'd21,
    OP_SETS = 8'd22,
    OP_GETS = 8'd23,
    OP_SETL = 8'd24,
    OP_GETL = 8'd25,
    OP_EQ   = 8'd26,
    OP_GT   = 8'd27,
    OP_LT   = 8'd28,
    OP_TRUE = 8'd29,
    OP_FALSE = 8'd30,
    OP_FLAG = 8'd31
  } op_e;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_LIT,
    S_RD,
    S_MOD,
    S_MRD,
    S_EX,
    S_DIV,
    S_EX2,
    S_FIN,
    S_OUT
  } state_e;

endpackage

FILE: sv/smc_in_if.sv
interface smc_in_if import smc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] instruction_word;

  modport source (output valid, output instruction_word, input ready);
  modport sink (input valid, input instruction_word, output ready);
endinterface

FILE: sv/smc_out_if.sv
interface smc_out_if import smc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [WordW-1:0]        fetch_address;
  logic                    halted;
  logic signed [WordW-1:0] top_of_stack;

  modport source (output valid, output fetch_address, output halted, output top_of_stack,
                  input ready);
  modport sink (input valid, input fetch_address, input halted, input top_of_stack,
                output ready);
endinterface

FILE: sv/stack_machine_core_unit.sv
// Channel | Dir | Handshake     | Payload
// in_i    | in  | valid / ready | instruction_word[15:0]
// out_o   | out | valid / ready | fetch_address[15:0], halted, top_of_stack[15:0]
//
// A literal word passes through S_LIT, S_FIN and S_OUT to a registered result.
// Each opcode is a stack memory read, then an execute step; swap adds a write step,
// divide a 16-step divider, byte opcodes an 8-step address reduction and a byte read.
// After reset the data memory is cleared, one byte a cycle, with in_i.ready low.
// A stalled result waits in the output register while the
// next word is accepted; that word completes once the register is free.
module stack_machine_core_unit import smc_pkg::*; #(
  parameter int unsigned STACK_DEPTH       = 16,
  parameter int unsigned DATA_MEMORY_BYTES = 4096
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  smc_in_if.sink    in_i,
  smc_out_if.source out_o
);

  localparam int unsigned SW = $clog2(STACK_DEPTH);
  localparam int unsigned MW = $clog2(DATA_MEMORY_BYTES);
  localparam logic [23:0] MemBytes24 = 24'(DATA_MEMORY_BYTES);

  function automatic logic [SW-1:0] sp_up(input logic [SW-1:0] p);
    return (p == SW'(STACK_DEPTH - 1)) ? '0 : SW'(p + 1'b1);
  endfunction

  function automatic logic [SW-1:0] sp_dn(input logic [SW-1:0] p);
    return (p == '0) ? SW'(STACK_DEPTH - 1) : SW'(p - 1'b1);
  endfunction

  state_e               state_q, state_d;
  logic [WordW-1:0]     ip_q, ip_d;
  logic [SW-1:0]        dsp_q, dsp_d;
  logic [SW-1:0]        rsp_q, rsp_d;
  logic [WordW-1:0]     sptr_q, sptr_d;
  logic [WordW-1:0]     lptr_q, lptr_d;
  logic                 halt_q, halt_d;
  logic [WordW-1:0]     word_q, word_d;
  logic                 slot_q, slot_d;
  logic [WordW-1:0]     wr2_q, wr2_d;
  logic [WordW-1:0]     modx_q, modx_d;
  logic [2:0]           modk_q, modk_d;
  logic [MW-1:0]        clr_q, clr_d;
  logic                 outv_q, outv_d;
  logic [WordW-1:0]     oip_q, oip_d;
  logic                 ohalt_q, ohalt_d;
  logic [WordW-1:0]     otos_q, otos_d;
  logic [STACK_DEPTH-1:0] dv_q, rv_q;

  logic                 ds_we, rs_we, mem_we;
  logic [SW-1:0]        ds_waddr, rs_waddr;
  logic [WordW-1:0]     ds_wdata, rs_wdata;
  logic [MW-1:0]        mem_waddr;
  logic [ByteW-1:0]     mem_wdata;
  logic [WordW-1:0]     ds_rda, ds_rdb, rs_rda;
  logic [ByteW-1:0]     mem_rd;
  logic [SW-1:0]        nsp;
  logic [WordW-1:0]     tos, nos, rtop, fbyte;
  logic [2*WordW-1:0]   prod;
  logic [23:0]          mod_cmp;
  logic [7:0]           op_byte;
  op_e                  op;
  logic                 div_start, div_done;
  logic [WordW-1:0]     div_q, div_r;
  logic                 word_end;

  assign nsp     = sp_dn(dsp_q);
  assign tos     = dv_q[dsp_q] ? ds_rda : '0;
  assign nos     = dv_q[nsp] ? ds_rdb : '0;
  assign rtop    = rv_q[rsp_q] ? rs_rda : '0;
  assign fbyte   = {{(WordW-ByteW){mem_rd[ByteW-1]}}, mem_rd};
  assign prod    = nos * tos;
  assign mod_cmp = MemBytes24 << modk_q;
  assign op_byte = slot_q ? word_q[15:8] : word_q[7:0];
  assign op      = op_e'(op_byte);

  smc_ram #(.WIDTH(WordW), .DEPTH(STACK_DEPTH)) u_dstack (
    .clk_i     (clk_i),
    .we_i      (ds_we),
    .waddr_i   (ds_waddr),
    .wdata_i   (ds_wdata),
    .raddr_a_i (dsp_q),
    .raddr_b_i (nsp),
    .rdata_a_o (ds_rda),
    .rdata_b_o (ds_rdb)
  );

  smc_ram #(.WIDTH(WordW), .DEPTH(STACK_DEPTH)) u_rstack (
    .clk_i     (clk_i),
    .we_i      (rs_we),
    .waddr_i   (rs_waddr),
    .wdata_i   (rs_wdata),
    .raddr_a_i (rsp_q),
    .raddr_b_i (rsp_q),
    .rdata_a_o (rs_rda),
    .rdata_b_o ()
  );

  smc_ram #(.WIDTH(ByteW), .DEPTH(DATA_MEMORY_BYTES)) u_dmem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (modx_q[MW-1:0]),
    .raddr_b_i (modx_q[MW-1:0]),
    .rdata_a_o (mem_rd),
    .rdata_b_o ()
  );

  smc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (nos),
    .divisor_i  (tos),
    .done_o     (div_done),
    .quot_o     (div_q),
    .rem_o      (div_r)
  );

  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = outv_q;
  assign out_o.fetch_address = oip_q;
  assign out_o.halted        = ohalt_q;
  assign out_o.top_of_stack  = otos_q;

  // sequence one word: decode, read, execute, write back
  always_comb begin
    state_d   = state_q;
    ip_d      = ip_q;
    dsp_d     = dsp_q;
    rsp_d     = rsp_q;
    sptr_d    = sptr_q;
    lptr_d    = lptr_q;
    halt_d    = halt_q;
    word_d    = word_q;
    slot_d    = slot_q;
    wr2_d     = wr2_q;
    modx_d    = modx_q;
    modk_d    = modk_q;
    clr_d     = clr_q;
    outv_d    = outv_q && !out_o.ready;
    oip_d     = oip_q;
    ohalt_d   = ohalt_q;
    otos_d    = otos_q;
    ds_we     = 1'b0;
    ds_waddr  = dsp_q;
    ds_wdata  = '0;
    rs_we     = 1'b0;
    rs_waddr  = sp_up(rsp_q);
    rs_wdata  = '0;
    mem_we    = 1'b0;
    mem_waddr = modx_q[MW-1:0];
    mem_wdata = tos[ByteW-1:0];
    div_start = 1'b0;
    word_end  = 1'b0;

    unique case (state_q)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = MW'(clr_q + 1'b1);
        if (clr_q == MW'(DATA_MEMORY_BYTES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_i.valid) begin
          word_d = in_i.instruction_word;
          slot_d = 1'b0;
          if (halt_q) begin
            state_d = S_FIN;
          end else begin
            ip_d    = WordW'(ip_q + 1'b1);
            state_d = in_i.instruction_word[LitBit] ? S_LIT : S_RD;
          end
        end
      end
      S_LIT: begin
        ds_we    = 1'b1;
        ds_waddr = sp_up(dsp_q);
        ds_wdata = word_q & LitMask;
        dsp_d    = sp_up(dsp_q);
        state_d  = S_FIN;
      end
      S_RD: begin
        // byte opcodes first reduce their pointer to a memory address
        if (op == OP_STB || op == OP_ADDB) begin
          modx_d  = sptr_q;
          modk_d  = 3'(ModSteps - 1);
          state_d = S_MOD;
        end else if (op == OP_FETB || op == OP_ADDF) begin
          modx_d  = lptr_q;
          modk_d  = 3'(ModSteps - 1);
          state_d = S_MOD;
        end else begin
          state_d = S_EX;
        end
      end
      S_MOD: begin
        if ({8'h00, modx_q} >= mod_cmp) begin
          modx_d = modx_q - mod_cmp[WordW-1:0];
        end
        modk_d = modk_q - 3'd1;
        if (modk_q == '0) begin
          state_d = S_MRD;
        end
      end
      S_MRD: begin
        state_d = S_EX;
      end
      S_EX: begin
        state_d = S_RD;
        unique case (op)
          OP_NOP: word_end = 1'b1;
          OP_CALL: begin
            rs_we    = 1'b1;
            rs_wdata = ip_q;
            rsp_d    = sp_up(rsp_q);
            ip_d     = ip_q - tos;
            dsp_d    = nsp;
            word_end = 1'b1;
          end
          OP_RET: begin
            ip_d     = rtop;
            rsp_d    = sp_dn(rsp_q);
            word_end = 1'b1;
          end
          OP_IF: begin
            dsp_d = sp_dn(nsp);
            if (nos != '0) begin
              ip_d     = ip_q - tos;
              word_end = 1'b1;
            end
          end
          OP_NEG: begin
            ds_we    = 1'b1;
            ds_wdata = WordW'(0 - tos);
          end
          OP_NOT: begin
            ds_we    = 1'b1;
            ds_wdata = ~tos;
          end
          OP_ADD, OP_MUL, OP_AND, OP_OR, OP_XOR, OP_EQ, OP_GT, OP_LT: begin
            ds_we    = 1'b1;
            ds_waddr = nsp;
            dsp_d    = nsp;
            unique case (op)
              OP_ADD:  ds_wdata = nos + tos;
              OP_MUL:  ds_wdata = prod[WordW-1:0];
              OP_AND:  ds_wdata = nos & tos;
              OP_OR:   ds_wdata = nos | tos;
              OP_XOR:  ds_wdata = nos ^ tos;
              OP_EQ:   ds_wdata = (nos == tos) ? TrueWord : '0;
              OP_GT:   ds_wdata = ($signed(nos) > $signed(tos)) ? TrueWord : '0;
              default: ds_wdata = ($signed(nos) < $signed(tos)) ? TrueWord : '0;
            endcase
          end
          OP_DIV: begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end
          OP_TOR: begin
            rs_we    = 1'b1;
            rs_wdata = tos;
            rsp_d    = sp_up(rsp_q);
            dsp_d    = nsp;
          end
          OP_DROP, OP_SETS, OP_SETL: begin
            dsp_d = nsp;
            if (op == OP_SETS) begin
              sptr_d = tos;
            end else if (op == OP_SETL) begin
              lptr_d = tos;
            end
          end
          OP_SWAP: begin
            ds_we    = 1'b1;
            ds_waddr = nsp;
            ds_wdata = tos;
            wr2_d    = nos;
            state_d  = S_EX2;
          end
          OP_STB, OP_ADDB: begin
            mem_we    = 1'b1;
            mem_wdata = (op == OP_ADDB) ? ByteW'(mem_rd + tos[ByteW-1:0]) : tos[ByteW-1:0];
            sptr_d    = WordW'(sptr_q + 1'b1);
            dsp_d     = nsp;
          end
          OP_ADDF: begin
            ds_we    = 1'b1;
            ds_wdata = tos + fbyte;
            lptr_d   = WordW'(lptr_q + 1'b1);
          end
          OP_FROMR, OP_DUP, OP_OVER, OP_FETB, OP_GETS, OP_GETL, OP_TRUE, OP_FALSE,
          OP_FLAG: begin
            ds_we    = 1'b1;
            ds_waddr = sp_up(dsp_q);
            dsp_d    = sp_up(dsp_q);
            unique case (op)
              OP_FROMR: begin
                ds_wdata = rtop;
                rsp_d    = sp_dn(rsp_q);
              end
              OP_DUP:  ds_wdata = tos;
              OP_OVER: ds_wdata = nos;
              OP_FETB: begin
                ds_wdata = fbyte;
                lptr_d   = WordW'(lptr_q + 1'b1);
              end
              OP_GETS: ds_wdata = sptr_q;
              OP_GETL: ds_wdata = lptr_q;
              OP_TRUE: ds_wdata = TrueWord;
              default: ds_wdata = '0;
            endcase
          end
          default: begin
            // unknown opcode: halt and skip the rest of the word
            halt_d   = 1'b1;
            word_end = 1'b1;
          end
        endcase
        if (state_d == S_RD) begin
          if (word_end || slot_q) begin
            state_d = S_FIN;
          end else begin
            slot_d = 1'b1;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          ds_we    = 1'b1;
          ds_waddr = nsp;
          ds_wdata = div_q;
          wr2_d    = div_r;
          state_d  = S_EX2;
        end
      end
      S_EX2: begin
        ds_we    = 1'b1;
        ds_waddr = dsp_q;
        ds_wdata = wr2_q;
        if (slot_q) begin
          state_d = S_FIN;
        end else begin
          slot_d  = 1'b1;
          state_d = S_RD;
        end
      end
      S_FIN: begin
        // let the stack top read settle after the last write
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!outv_q || out_o.ready) begin
          outv_d  = 1'b1;
          oip_d   = ip_q;
          ohalt_d = halt_q;
          otos_d  = tos;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      ip_q    <= '0;
      dsp_q   <= '0;
      rsp_q   <= '0;
      sptr_q  <= '0;
      lptr_q  <= '0;
      halt_q  <= 1'b0;
      slot_q  <= 1'b0;
      clr_q   <= '0;
      outv_q  <= 1'b0;
      dv_q    <= '0;
      rv_q    <= '0;
    end else begin
      state_q <= state_d;
      ip_q    <= ip_d;
      dsp_q   <= dsp_d;
      rsp_q   <= rsp_d;
      sptr_q  <= sptr_d;
      lptr_q  <= lptr_d;
      halt_q  <= halt_d;
      slot_q  <= slot_d;
      clr_q   <= clr_d;
      outv_q  <= outv_d;
      if (ds_we) begin
        dv_q[ds_waddr] <= 1'b1;
      end
      if (rs_we) begin
        rv_q[rs_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q  <= word_d;
    wr2_q   <= wr2_d;
    modx_q  <= modx_d;
    modk_q  <= modk_d;
    oip_q   <= oip_d;
    ohalt_q <= ohalt_d;
    otos_q  <= otos_d;
  end

`ifndef NO_ASSERTIONS
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q) else $error("halt mark cleared");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV) else $error("divider finished outside divide wait");

  a_mem_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_CLR || state_q == S_EX)) else $error("stray memory write");
`endif

endmodule

FILE: sv/smc_ram.sv
module smc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

FILE: sv/smc_div.sv
module smc_div import smc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WordW-1:0] dividend_i,
  input  logic [WordW-1:0] divisor_i,
  output logic             done_o,
  output logic [WordW-1:0] quot_o,
  output logic [WordW-1:0] rem_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [3:0]           cnt_q, cnt_d;
  logic [WordW:0]       rem_q, rem_d;
  logic [WordW-1:0]     quo_q, quo_d;
  logic [WordW-1:0]     den_q, den_d;
  logic [WordW-1:0]     num_q, num_d;
  logic                 negq_q, negq_d;
  logic                 negr_q, negr_d;
  logic                 zero_q, zero_d;
  logic [WordW:0]       shifted;
  logic [WordW+1:0]     trial;

  assign shifted = {rem_q[WordW-1:0], quo_q[WordW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den_q};

  // one restoring step per cycle on magnitudes
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    num_d  = num_q;
    negq_d = negq_q;
    negr_d = negr_q;
    zero_d = zero_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '1;
      rem_d  = '0;
      quo_d  = dividend_i[WordW-1] ? WordW'(0 - dividend_i) : dividend_i;
      den_d  = divisor_i[WordW-1] ? WordW'(0 - divisor_i) : divisor_i;
      num_d  = dividend_i;
      negq_d = dividend_i[WordW-1] ^ divisor_i[WordW-1];
      negr_d = dividend_i[WordW-1];
      zero_d = (divisor_i == '0);
    end else if (busy_q) begin
      if (!trial[WordW+1]) begin
        rem_d = trial[WordW:0];
        quo_d = {quo_q[WordW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[WordW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 4'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    den_q  <= den_d;
    num_q  <= num_d;
    negq_q <= negq_d;
    negr_q <= negr_d;
    zero_q <= zero_d;
  end

  // apply signs, truncating toward zero; zero divisor returns a zero quotient and the dividend as remainder
  assign done_o = done_q;
  assign quot_o = zero_q ? '0 : (negq_q ? WordW'(0 - quo_q) : quo_q);
  assign rem_o  = zero_q ? num_q
                         : (negr_q ? WordW'(0 - rem_q[WordW-1:0]) : rem_q[WordW-1:0]);

endmodule

FILE: tb/tb_stack_machine_core_unit.sv
`timescale 1ns / 1ps

module tb_stack_machine_core_unit;
  import smc_pkg::*;

  localparam int unsigned Depth = 16;
  localparam int unsigned MemBytes = 4096;
  localparam int unsigned NumRandom = 750;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [WordW-1:0] fetch_address;
    logic             halted;
    logic [WordW-1:0] top_of_stack;
  } core_result_t;

  typedef struct {
    logic [WordW-1:0] word;
    logic             has_result;
    core_result_t     result;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  smc_in_if  in_ch ();
  smc_out_if out_ch ();

  stack_machine_core_unit #(
    .STACK_DEPTH      (Depth),
    .DATA_MEMORY_BYTES(MemBytes)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  // Shadow machine state
  logic [WordW-1:0] sh_ip;
  logic [WordW-1:0] sh_dstk [Depth];
  logic [WordW-1:0] sh_rstk [Depth];
  logic [3:0]       sh_dsp;
  logic [3:0]       sh_rsp;
  logic [WordW-1:0] sh_sptr;
  logic [WordW-1:0] sh_lptr;
  logic [ByteW-1:0] sh_mem [MemBytes];
  logic             sh_halt;

  core_result_t result_q [$];
  int           fail_cnt;
  int           cycle_cnt = 0;
  logic         hold_off;
  stim_row_t    rows [$];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void push_data(logic [WordW-1:0] v);
    sh_dsp = sh_dsp + 4'd1;
    sh_dstk[sh_dsp] = v;
  endfunction

  function automatic logic [WordW-1:0] sext_byte(logic [ByteW-1:0] b);
    return {{8{b[7]}}, b};
  endfunction

  // Execute one opcode; 0 continue, 1 end of word, 2 halt
  function automatic int run_opcode(logic [7:0] op);
    logic [3:0]       t;
    logic [3:0]       n;
    logic [WordW-1:0] tos;
    logic [WordW-1:0] nos;
    logic signed [WordW-1:0] sa;
    logic signed [WordW-1:0] sb;
    int               ad;
    t = sh_dsp;
    n = sh_dsp - 4'd1;
    tos = sh_dstk[t];
    nos = sh_dstk[n];
    sa = nos;
    sb = tos;
    if (op > OP_FLAG) return 2;
    case (op_e'(op))
      OP_NOP: return 1;
      OP_CALL: begin
        sh_rsp = sh_rsp + 4'd1;
        sh_rstk[sh_rsp] = sh_ip;
        sh_ip = sh_ip - tos;
        sh_dsp = n;
        return 1;
      end
      OP_RET: begin
        sh_ip = sh_rstk[sh_rsp];
        sh_rsp = sh_rsp - 4'd1;
        return 1;
      end
      OP_IF: begin
        sh_dsp = t - 4'd2;
        if (nos != '0) begin
          sh_ip = sh_ip - tos;
          return 1;
        end
      end
      OP_NEG: sh_dstk[t] = -tos;
      OP_ADD: begin sh_dstk[n] = nos + tos; sh_dsp = n; end
      OP_MUL: begin sh_dstk[n] = nos * tos; sh_dsp = n; end
      OP_DIV: begin
        if (tos == '0) begin
          sh_dstk[n] = '0;
          sh_dstk[t] = nos;
        end else if (nos == 16'h8000 && tos == 16'hffff) begin
          sh_dstk[n] = 16'h8000;
          sh_dstk[t] = '0;
        end else begin
          sh_dstk[n] = sa / sb;
          sh_dstk[t] = sa % sb;
        end
      end
      OP_NOT: sh_dstk[t] = ~tos;
      OP_AND: begin sh_dstk[n] = nos & tos; sh_dsp = n; end
      OP_OR: begin sh_dstk[n] = nos | tos; sh_dsp = n; end
      OP_XOR: begin sh_dstk[n] = nos ^ tos; sh_dsp = n; end
      OP_TOR: begin
        sh_rsp = sh_rsp + 4'd1;
        sh_rstk[sh_rsp] = tos;
        sh_dsp = n;
      end
      OP_FROMR: begin
        push_data(sh_rstk[sh_rsp]);
        sh_rsp = sh_rsp - 4'd1;
      end
      OP_DUP: push_data(tos);
      OP_DROP: sh_dsp = n;
      OP_SWAP: begin sh_dstk[n] = tos; sh_dstk[t] = nos; end
      OP_OVER: push_data(nos);
      OP_STB: begin
        sh_mem[sh_sptr % MemBytes] = tos[7:0];
        sh_sptr = sh_sptr + 16'd1;
        sh_dsp = n;
      end
      OP_ADDB: begin
        ad = sh_sptr % MemBytes;
        sh_mem[ad] = sh_mem[ad] + tos[7:0];
        sh_sptr = sh_sptr + 16'd1;
        sh_dsp = n;
      end
      OP_FETB: begin
        push_data(sext_byte(sh_mem[sh_lptr % MemBytes]));
        sh_lptr = sh_lptr + 16'd1;
      end
      OP_ADDF: begin
        sh_dstk[t] = tos + sext_byte(sh_mem[sh_lptr % MemBytes]);
        sh_lptr = sh_lptr + 16'd1;
      end
      OP_SETS: begin sh_sptr = tos; sh_dsp = n; end
      OP_GETS: push_data(sh_sptr);
      OP_SETL: begin sh_lptr = tos; sh_dsp = n; end
      OP_GETL: push_data(sh_lptr);
      OP_EQ: begin sh_dstk[n] = (nos == tos) ? TrueWord : '0; sh_dsp = n; end
      OP_GT: begin sh_dstk[n] = (sa > sb) ? TrueWord : '0; sh_dsp = n; end
      OP_LT: begin sh_dstk[n] = (sa < sb) ? TrueWord : '0; sh_dsp = n; end
      OP_TRUE: push_data(TrueWord);
      OP_FALSE, OP_FLAG: push_data('0);
      default: return 2;
    endcase
    return 0;
  endfunction

  // Advance the shadow core by one instruction word
  function automatic core_result_t step_core(logic [WordW-1:0] w);
    core_result_t r;
    int s;
    if (!sh_halt) begin
      sh_ip = sh_ip + 16'd1;
      if (w[LitBit]) begin
        push_data(w & LitMask);
      end else begin
        s = run_opcode(w[7:0]);
        if (s == 0) s = run_opcode(w[15:8]);
        if (s == 2) sh_halt = 1'b1;
      end
    end
    r.fetch_address = sh_ip;
    r.halted = sh_halt;
    r.top_of_stack = sh_dstk[sh_dsp];
    return r;
  endfunction

  function automatic logic [WordW-1:0] ops(op_e lo, op_e hi);
    return {hi, lo};
  endfunction

  function automatic logic [WordW-1:0] lit(int unsigned v);
    return 16'h8000 | (WordW'(v) & LitMask);
  endfunction

  task automatic add_row(logic [WordW-1:0] w);
    rows.push_back('{w, 1'b0, '0});
  endtask

  task automatic add_known(logic [WordW-1:0] w, logic [WordW-1:0] fa, logic h,
                           logic [WordW-1:0] tos);
    rows.push_back('{w, 1'b1, '{fa, h, tos}});
  endtask

  // Random well-formed word: mostly opcode pairs, some literals, rare calls/rets
  function automatic logic [WordW-1:0] rand_word();
    int unsigned k;
    logic [7:0] lo;
    logic [7:0] hi;
    k = $urandom_range(99);
    if (k < 30) return 16'h8000 | WordW'($urandom_range(16'h7fff));
    if (k < 34) return 16'h8000 | WordW'($urandom_range(7));
    lo = 8'($urandom_range(4, 31));
    hi = 8'($urandom_range(4, 31));
    if (k < 38) lo = 8'($urandom_range(0, 3));
    if (k < 42) hi = 8'($urandom_range(0, 3));
    return {hi, lo};
  endfunction

  // Offer one word at a falling edge; valid stays high when the next gap is zero
  task automatic send_word(logic [WordW-1:0] w, logic has_exp, core_result_t exp_r);
    core_result_t pred;
    int unsigned gap;
    gap = $urandom_range(7);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.instruction_word <= w;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    pred = step_core(w);
    if (has_exp && pred !== exp_r) begin
      $error("directed row 0x%04h: table 0x%h, predictor 0x%h", w, exp_r, pred);
      fail_cnt++;
    end
    result_q.push_back(has_exp ? exp_r : pred);
    @(negedge clk_i);
  endtask

  // Cycle count and timeout
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off
  initial begin
    int wait_cyc;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
      end else begin
        wait_cyc = ($urandom_range(3) == 0) ? 0 : $urandom_range(7);
        if (wait_cyc != 0) begin
          out_ch.ready <= 1'b0;
          repeat (wait_cyc - 1) @(negedge clk_i);
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Compare each accepted transaction with the oldest expectation
  always @(posedge clk_i) begin
    core_result_t exp_r;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (result_q.size() == 0) begin
        $error("unexpected result transaction");
        fail_cnt++;
      end else begin
        exp_r = result_q.pop_front();
        if (out_ch.fetch_address !== exp_r.fetch_address) begin
          $error("fetch_address: expected 0x%04h, actual 0x%04h",
                 exp_r.fetch_address, out_ch.fetch_address);
          fail_cnt++;
        end
        if (out_ch.halted !== exp_r.halted) begin
          $error("halted: expected %0d, actual %0d", exp_r.halted, out_ch.halted);
          fail_cnt++;
        end
        if (out_ch.top_of_stack !== exp_r.top_of_stack) begin
          $error("top_of_stack: expected 0x%04h, actual 0x%04h",
                 exp_r.top_of_stack, out_ch.top_of_stack);
          fail_cnt++;
        end
      end
    end
  end

  // Long hold-off while the sender keeps offering words
  initial begin
    hold_off = 1'b0;
    @(posedge rst_ni);
    repeat (MemBytes + 3000) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Stimulus
  initial begin
    int idx;
    fail_cnt = 0;
    in_ch.valid = 1'b0;
    in_ch.instruction_word = '0;
    sh_ip = '0;
    sh_dsp = '0;
    sh_rsp = '0;
    sh_sptr = '0;
    sh_lptr = '0;
    sh_halt = 1'b0;
    for (idx = 0; idx < Depth; idx++) begin
      sh_dstk[idx] = '0;
      sh_rstk[idx] = '0;
    end
    for (idx = 0; idx < MemBytes; idx++) sh_mem[idx] = '0;

    // Directed table: extremes, every opcode, division by zero, memory wrap
    add_known(lit(16'h7fff), 16'd1, 1'b0, 16'h7fff);
    add_known(lit(0), 16'd2, 1'b0, 16'h0000);
    add_known(ops(OP_TRUE, OP_NOP), 16'd3, 1'b0, 16'hffff);
    add_row(ops(OP_NEG, OP_DUP));
    add_row(ops(OP_ADD, OP_MUL));
    add_row(ops(OP_NOT, OP_OVER));
    add_row(ops(OP_AND, OP_OR));
    add_row(ops(OP_XOR, OP_SWAP));
    add_row(lit(0));
    add_row(ops(OP_DIV, OP_EQ));
    add_row(ops(OP_FALSE, OP_TRUE));
    add_row(ops(OP_NOT, OP_DROP));
    add_row(lit(16'h7fff));
    add_row(ops(OP_GT, OP_LT));
    add_row(lit(16'h0fff));
    add_row(ops(OP_SETS, OP_GETS));
    add_row(ops(OP_STB, OP_ADDB));
    add_row(ops(OP_FLAG, OP_SETL));
    add_row(ops(OP_GETL, OP_FETB));
    add_row(ops(OP_ADDF, OP_TOR));
    add_row(ops(OP_FROMR, OP_IF));
    add_row(ops(OP_CALL, OP_DUP));
    add_row(ops(OP_RET, OP_NEG));

    @(posedge rst_ni);
    @(negedge clk_i);
    foreach (rows[i]) send_word(rows[i].word, rows[i].has_result, rows[i].result);

    // Random well-formed words
    for (idx = 0; idx < NumRandom; idx++) send_word(rand_word(), 1'b0, '0);

    // Division overflow, then an unknown opcode and words ignored while halted
    send_word(lit(16'h7fff), 1'b0, '0);
    send_word(ops(OP_NOT, OP_NOP), 1'b0, '0);
    send_word(ops(OP_TRUE, OP_NOP), 1'b0, '0);
    send_word(ops(OP_DIV, OP_NOP), 1'b0, '0);
    send_word(16'h7f00 | 8'hff, 1'b0, '0);
    for (idx = 0; idx < 8; idx++) send_word(WordW'($urandom_range(16'hffff)), 1'b0, '0);
    in_ch.valid <= 1'b0;

    while (result_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Reset, asserted once
  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

endmodule

FILE: sim.f
sv/smc_pkg.sv
sv/smc_in_if.sv
sv/smc_out_if.sv
sv/smc_ram.sv
sv/smc_div.sv
sv/stack_machine_core_unit.sv
tb/tb_stack_machine_core_unit.sv
